### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clk edge, quiet while arst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never be seen on a rising clk edge.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

### hw/rtl/cpr_pkg.sv
// Types, constants and the sine helper for the charging pulse row brightness core.
`default_nettype none
package cpr_pkg;

	localparam int unsigned CPR_ADDR_W   = 5;
	localparam int unsigned CPR_MAX_ROWS = 256;
	localparam int unsigned CPR_ASC_W    = 24;
	localparam int unsigned CPR_CYC_W    = 25;

	// Register map, word index
	typedef enum logic [2:0] {
		REG_STEP  = 3'd0,
		REG_FLASH = 3'd1,
		REG_FADE  = 3'd2,
		REG_BASE  = 3'd3,
		REG_ROWS  = 3'd4,
		REG_HUE   = 3'd5,
		REG_SAT   = 3'd6
	} cpr_reg_t;

	// Animation phase of one beat
	typedef enum logic [1:0] {
		PH_ASC   = 2'd0,
		PH_FLASH = 2'd1,
		PH_FADE  = 2'd2,
		PH_DARK  = 2'd3
	} cpr_phase_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [7:0]  row_index;
	} cpr_item_t;

	typedef struct packed {
		logic [7:0] row_echo;
		logic [7:0] brightness;
		logic       lit;
		logic [7:0] hue_out;
		logic [7:0] saturation_out;
	} cpr_result_t;

	// Register values plus derived cycle geometry
	typedef struct packed {
		logic [15:0]          step;
		logic [15:0]          flash;
		logic [15:0]          fade;
		logic [7:0]           base;
		logic [7:0]           hue;
		logic [7:0]           sat;
		logic [8:0]           h;
		logic [CPR_ASC_W-1:0] ascend;
		logic [CPR_CYC_W-1:0] cycle;
	} cpr_cfg_t;

	// Per-beat control that rides down the pipeline
	typedef struct packed {
		logic [7:0] row;
		cpr_phase_t phase;
		logic       row_ok;
		logic       started;
		logic       ramp;
	} cpr_ctl_t;

	// Piecewise-linear sine: base/slope pairs per quarter-wave segment
	localparam logic [7:0] SINE_SEG [8] = '{8'd0, 8'd49, 8'd49, 8'd41,
		8'd90, 8'd27, 8'd117, 8'd10};

	function automatic logic [7:0] sine8(input logic [7:0] theta);
		logic [7:0]  off;
		logic [4:0]  sec;
		logic [1:0]  seg;
		logic [7:0]  b;
		logic [7:0]  m;
		logic [12:0] prod;
		logic [7:0]  y;
		off  = theta[6] ? ~theta : theta;
		sec  = {1'b0, off[3:0]} + {4'd0, theta[6]};
		seg  = off[5:4];
		b    = SINE_SEG[{seg, 1'b0}];
		m    = SINE_SEG[{seg, 1'b1}];
		prod = 13'(m) * 13'(sec);
		y    = prod[11:4] + b;
		if (theta[7]) begin
			y = 8'd0 - y;
		end
		return y + 8'd128;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/cpr_divlane.sv
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none
`include "assert_macros.svh"
module cpr_divlane #(
	parameter int DW     = 24,
	parameter int STEPS  = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DW-1:0]     in_rem,
	input  logic [DW-1:0]     in_div,
	input  logic [STEPS-1:0]  in_bits,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [DW-1:0]     out_rem,
	output logic [STEPS-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic [STEPS-1:0]  vld_s;
	logic [DW-1:0]     rem_s  [STEPS];
	logic [DW-1:0]     div_s  [STEPS];
	logic [STEPS-1:0]  bits_s [STEPS];
	logic [STEPS-1:0]  quo_s  [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];

	genvar k;
	for (k = 0; k < STEPS; k++) begin : g_step
		logic              pv;
		logic [DW-1:0]     prem;
		logic [DW-1:0]     pdiv;
		logic [STEPS-1:0]  pbits;
		logic [STEPS-1:0]  pquo;
		logic [SIDE_W-1:0] pside;
		logic [DW:0]       trial;
		logic              take;

		if (k == 0) begin : g_head
			assign pv    = in_valid;
			assign prem  = in_rem;
			assign pdiv  = in_div;
			assign pbits = in_bits;
			assign pquo  = '0;
			assign pside = in_side;
		end else begin : g_body
			assign pv    = vld_s[k-1];
			assign prem  = rem_s[k-1];
			assign pdiv  = div_s[k-1];
			assign pbits = bits_s[k-1];
			assign pquo  = quo_s[k-1];
			assign pside = side_s[k-1];
		end

		// shift in next dividend bit, subtract when it fits
		assign trial = {prem, pbits[STEPS-1]};
		assign take  = trial >= {1'b0, pdiv};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? DW'(trial - {1'b0, pdiv}) : DW'(trial);
			div_s[k]  <= pdiv;
			bits_s[k] <= pbits << 1;
			quo_s[k]  <= {pquo[STEPS-2:0], take};
			side_s[k] <= pside;
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_rem   = rem_s[STEPS-1];
	assign out_quo   = quo_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

	`ASSERT_CLK(a_rem_below_div, (out_valid && div_s[STEPS-1] != '0) |-> (out_rem < div_s[STEPS-1]), "divider remainder not reduced")

endmodule
`default_nettype wire

### hw/rtl/cpr_ease.sv
// Three-stage cubic in-out easing curve in unsigned fixed point.
`default_nettype none
module cpr_ease #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic [FRAC_BITS-1:0] p,
	output logic [FRAC_BITS:0]   e
);

	localparam int F = FRAC_BITS;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	logic           half;
	logic [F:0]     x;
	logic [2*F+1:0] sq_full;
	logic [2*F+1:0] cube_full;
	logic [F:0]     x_s1;
	logic [F:0]     sq_s1;
	logic           half_s1;
	logic           zero_s1;
	logic [F:0]     c_s2;
	logic           half_s2;
	logic           zero_s2;
	logic [F:0]     e_s3;

	// stage 1: fold upper half, square
	assign half    = !p[F-1];
	assign x       = half ? {1'b0, p} : {ONE[F-1:0] - p, 1'b0};
	assign sq_full = (2*F+2)'(x) * (2*F+2)'(x);

	always_ff @(posedge clk) begin
		x_s1    <= x;
		sq_s1   <= sq_full[2*F:F];
		half_s1 <= half;
		zero_s1 <= (p == '0);
	end

	// stage 2: cube
	assign cube_full = (2*F+2)'(sq_s1) * (2*F+2)'(x_s1);

	always_ff @(posedge clk) begin
		c_s2    <= cube_full[2*F:F];
		half_s2 <= half_s1;
		zero_s2 <= zero_s1;
	end

	// stage 3: scale and mirror
	always_ff @(posedge clk) begin
		if (zero_s2) begin
			e_s3 <= '0;
		end else if (half_s2) begin
			e_s3 <= {c_s2[F-2:0], 2'b00};
		end else begin
			e_s3 <= ONE - (c_s2 >> 1);
		end
	end

	assign e = e_s3;

endmodule
`default_nettype wire

### hw/rtl/cpr_cfg.sv
// APB register file and derived cycle geometry.
`default_nettype none
`include "assert_macros.svh"
module cpr_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cpr_pkg::CPR_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output cpr_pkg::cpr_cfg_t               cfg
);

	import cpr_pkg::*;

	logic [15:0]          step_q;
	logic [15:0]          flash_q;
	logic [15:0]          fade_q;
	logic [7:0]           base_q;
	logic [8:0]           rows_q;
	logic [7:0]           hue_q;
	logic [7:0]           sat_q;
	logic [8:0]           h_q;
	logic [CPR_ASC_W-1:0] ascend_q;
	logic [CPR_CYC_W-1:0] cycle_q;

	cpr_reg_t             idx;
	logic                 wr;
	logic [8:0]           h_c;
	logic [CPR_ASC_W-1:0] ascend_c;
	logic [CPR_CYC_W-1:0] cycle_c;

	assign idx    = cpr_reg_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 16'd40;
			flash_q <= 16'd200;
			fade_q  <= 16'd400;
			base_q  <= 8'd128;
			rows_q  <= 9'd8;
			hue_q   <= 8'd96;
			sat_q   <= 8'd255;
		end else if (wr) begin
			case (idx)
				REG_STEP:  step_q  <= pwdata[15:0];
				REG_FLASH: flash_q <= pwdata[15:0];
				REG_FADE:  fade_q  <= pwdata[15:0];
				REG_BASE:  base_q  <= pwdata[7:0];
				REG_ROWS:  rows_q  <= pwdata[8:0];
				REG_HUE:   hue_q   <= pwdata[7:0];
				REG_SAT:   sat_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// clamp height, ascend length, whole cycle (never zero)
	always_comb begin
		if (rows_q == 9'd0) begin
			h_c = 9'd1;
		end else if (rows_q > 9'(CPR_MAX_ROWS)) begin
			h_c = 9'(CPR_MAX_ROWS);
		end else begin
			h_c = rows_q;
		end
		ascend_c = CPR_ASC_W'(25'(h_c) * 25'(step_q));
		cycle_c  = CPR_CYC_W'(ascend_c) + CPR_CYC_W'(flash_q) + CPR_CYC_W'(fade_q);
		if (cycle_c == '0) begin
			cycle_c = CPR_CYC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q      <= 9'd8;
			ascend_q <= CPR_ASC_W'(320);
			cycle_q  <= CPR_CYC_W'(920);
		end else begin
			h_q      <= h_c;
			ascend_q <= ascend_c;
			cycle_q  <= cycle_c;
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_STEP:  prdata = {16'd0, step_q};
			REG_FLASH: prdata = {16'd0, flash_q};
			REG_FADE:  prdata = {16'd0, fade_q};
			REG_BASE:  prdata = {24'd0, base_q};
			REG_ROWS:  prdata = {23'd0, rows_q};
			REG_HUE:   prdata = {24'd0, hue_q};
			REG_SAT:   prdata = {24'd0, sat_q};
			default:   prdata = 32'd0;
		endcase
	end

	always_comb begin
		cfg.step   = step_q;
		cfg.flash  = flash_q;
		cfg.fade   = fade_q;
		cfg.base   = base_q;
		cfg.hue    = hue_q;
		cfg.sat    = sat_q;
		cfg.h      = h_q;
		cfg.ascend = ascend_q;
		cfg.cycle  = cycle_q;
	end

	`ASSERT_CLK(a_rows_written, (wr && idx == REG_ROWS) |=> (rows_q == $past(pwdata[8:0])), "row count write lost")
	`ASSERT_CLK(a_h_range, (h_q != 9'd0) && (h_q <= 9'(CPR_MAX_ROWS)), "clamped height out of range")
	`ASSERT_NEVER(a_cycle_zero, cycle_q == '0, "cycle length zero")

endmodule
`default_nettype wire

### hw/rtl/charging_pulse_row_brightness_core.sv
// Top level of the charging pulse row brightness pipeline.
// One row query is taken per clock whenever start is high (busy stays low), and its
// result shows on result for exactly one cycle with done high, after passing the entry
// stage, the 32-stage modulo divider that wraps now_ms into the cycle, the phase decode
// and operand select stages, the FRAC_BITS-stage fraction dividers, the three-stage
// easing units and two product stages. Results cannot be held off by the receiver, so
// it must take every beat in the cycle it appears. Register writes must only happen
// while no query is in flight; a new query may follow the write in the next cycle.
`default_nettype none
`include "assert_macros.svh"
module charging_pulse_row_brightness_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  cpr_pkg::cpr_item_t             item,
	output logic                           done,
	output cpr_pkg::cpr_result_t           result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cpr_pkg::CPR_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	import cpr_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int QW = CPR_ASC_W;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	cpr_cfg_t cfg;

	cpr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline takes a beat every cycle
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// entry stage
	logic        vld_s1;
	logic [31:0] now_s1;
	logic [7:0]  row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		now_s1 <= item.now_ms;
		row_s1 <= item.row_index;
	end

	// wrap time into the cycle
	logic                 mod_vld;
	logic [CPR_CYC_W-1:0] t_m;
	logic [7:0]           row_m;

	cpr_divlane #(
		.DW     (CPR_CYC_W),
		.STEPS  (32),
		.SIDE_W (8)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_rem    ('0),
		.in_div    (cfg.cycle),
		.in_bits   (now_s1),
		.in_side   (row_s1),
		.out_valid (mod_vld),
		.out_rem   (t_m),
		.out_quo   (),
		.out_side  (row_m)
	);

	// phase decode, row start time, phase offsets
	cpr_ctl_t             ctl_c2;
	logic [8:0]           hm;
	logic [CPR_CYC_W-1:0] asc_w;
	logic [CPR_CYC_W-1:0] asc_fl_w;
	logic                 vld_s2;
	cpr_ctl_t             ctl_s2;
	logic [CPR_CYC_W-1:0] t_s2;
	logic [QW-1:0]        s_s2;
	logic [15:0]          tfl_s2;
	logic [15:0]          tfd_s2;

	assign hm       = cfg.h - 9'd1 - {1'b0, row_m};
	assign asc_w    = CPR_CYC_W'(cfg.ascend);
	assign asc_fl_w = asc_w + CPR_CYC_W'(cfg.flash);

	always_comb begin
		ctl_c2         = '0;
		ctl_c2.row     = row_m;
		ctl_c2.row_ok  = {1'b0, row_m} < cfg.h;
		if (t_m < asc_w) begin
			ctl_c2.phase = PH_ASC;
		end else if (t_m < asc_fl_w) begin
			ctl_c2.phase = PH_FLASH;
		end else if (cfg.fade != 16'd0) begin
			ctl_c2.phase = PH_FADE;
		end else begin
			ctl_c2.phase = PH_DARK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= mod_vld;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_c2;
		t_s2   <= t_m;
		s_s2   <= QW'(25'(hm) * 25'(cfg.step));
		tfl_s2 <= 16'(t_m - asc_w);
		tfd_s2 <= 16'(t_m - asc_fl_w);
	end

	// row ramp test, divider operand select
	cpr_ctl_t             ctl_c3;
	logic [CPR_CYC_W-1:0] d_c;
	logic [23:0]          x_c;
	logic [QW-1:0]        ra_c;
	logic [QW-1:0]        da_c;
	logic [F-1:0]         ba_c;
	logic                 vld_s3;
	cpr_ctl_t             ctl_s3;
	logic [QW-1:0]        ra_s3;
	logic [QW-1:0]        da_s3;
	logic [F-1:0]         ba_s3;
	logic [QW-1:0]        rb_s3;
	logic [QW-1:0]        db_s3;

	assign d_c = t_s2 - CPR_CYC_W'(s_s2);
	assign x_c = {tfl_s2, 8'd0} - 24'(tfl_s2);

	always_comb begin
		ctl_c3         = ctl_s2;
		ctl_c3.started = t_s2 >= CPR_CYC_W'(s_s2);
		ctl_c3.ramp    = ctl_c3.started && (d_c < CPR_CYC_W'(cfg.step));
		ba_c           = '0;
		case (ctl_s2.phase)
			PH_ASC: begin
				ra_c = t_s2[QW-1:0];
				da_c = cfg.ascend;
			end
			PH_FLASH: begin
				// tf*255 / flash: high part seeds the remainder, low byte shifts in
				ra_c = QW'(x_c[23:8]);
				da_c = QW'(cfg.flash);
				ba_c = F'(x_c[7:0]) << (F - 8);
			end
			PH_FADE: begin
				ra_c = QW'(tfd_s2);
				da_c = QW'(cfg.fade);
			end
			default: begin
				ra_c = '0;
				da_c = QW'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3 <= ctl_c3;
		ra_s3  <= ra_c;
		da_s3  <= da_c;
		ba_s3  <= ba_c;
		rb_s3  <= ctl_c3.ramp ? QW'(d_c[15:0]) : '0;
		db_s3  <= QW'(cfg.step);
	end

	// fraction dividers: lane A global ramp / flash / fade, lane B row ramp
	logic                      vld_l;
	logic [$bits(cpr_ctl_t)-1:0] side_l;
	cpr_ctl_t                  ctl_l;
	logic [F-1:0]              qa;
	logic [F-1:0]              qb;

	cpr_divlane #(
		.DW     (QW),
		.STEPS  (F),
		.SIDE_W ($bits(cpr_ctl_t))
	) u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_rem    (ra_s3),
		.in_div    (da_s3),
		.in_bits   (ba_s3),
		.in_side   (ctl_s3),
		.out_valid (vld_l),
		.out_rem   (),
		.out_quo   (qa),
		.out_side  (side_l)
	);

	cpr_divlane #(
		.DW     (QW),
		.STEPS  (F),
		.SIDE_W (1)
	) u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_rem    (rb_s3),
		.in_div    (db_s3),
		.in_bits   ('0),
		.in_side   (1'b0),
		.out_valid (),
		.out_rem   (),
		.out_quo   (qb),
		.out_side  ()
	);

	assign ctl_l = cpr_ctl_t'(side_l);

	// easing units, flash boost alongside
	logic [F:0] ea;
	logic [F:0] eb;

	cpr_ease #(.FRAC_BITS (F)) u_ease_a (
		.clk (clk),
		.p   (qa),
		.e   (ea)
	);

	cpr_ease #(.FRAC_BITS (F)) u_ease_b (
		.clk (clk),
		.p   (qb),
		.e   (eb)
	);

	logic        vld_s4;
	logic        vld_s5;
	logic        vld_s6;
	cpr_ctl_t    ctl_s4;
	cpr_ctl_t    ctl_s5;
	cpr_ctl_t    ctl_s6;
	logic [7:0]  sin_s4;
	logic [15:0] n_s5;
	logic [7:0]  vfl_s6;
	logic [16:0] nq;
	logic [8:0]  fsum;

	assign nq   = 17'(n_s5) + 17'(n_s5 >> 8) + 17'd1;
	assign fsum = 9'(cfg.base) + 9'(nq[15:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= vld_l;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s4 <= ctl_l;
		ctl_s5 <= ctl_s4;
		ctl_s6 <= ctl_s5;
		sin_s4 <= sine8(qa[F-1 -: 8]);
		n_s5   <= 16'(8'd255 - cfg.base) * 16'(sin_s4);
		// n / 255 without a divider, exact for n below 65535
		vfl_s6 <= (fsum > 9'd255) ? 8'd255 : fsum[7:0];
	end

	// products with base level
	logic           vld_s7;
	cpr_ctl_t       ctl_s7;
	logic [F+8:0]   prod_s7;
	logic [F:0]     ea_s7;
	logic [7:0]     vfull_s7;
	logic [7:0]     vfade_s7;
	logic [7:0]     vfl_s7;
	logic [F+8:0]   full_c;
	logic [F+8:0]   fade_c;

	assign full_c = (F+9)'(cfg.base) * (F+9)'(ea);
	assign fade_c = (F+9)'(cfg.base) * (F+9)'(ONE - ea);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s7   <= ctl_s6;
		prod_s7  <= (F+9)'(cfg.base) * (F+9)'(eb);
		ea_s7    <= ea;
		vfull_s7 <= full_c[F+7:F];
		vfade_s7 <= fade_c[F+7:F];
		vfl_s7   <= vfl_s6;
	end

	// final product, phase select, result register
	logic [2*F+9:0] ramp_c;
	logic [7:0]     v_c;
	logic           vld_s8;
	cpr_result_t    res_s8;

	assign ramp_c = (2*F+10)'(prod_s7) * (2*F+10)'(ea_s7);

	always_comb begin
		v_c = 8'd0;
		if (ctl_s7.row_ok) begin
			case (ctl_s7.phase)
				PH_ASC: begin
					if (ctl_s7.ramp) begin
						v_c = ramp_c[2*F+7:2*F];
					end else if (ctl_s7.started) begin
						v_c = vfull_s7;
					end
				end
				PH_FLASH: v_c = (ctl_s7.row == 8'd0) ? vfl_s7 : cfg.base;
				PH_FADE:  v_c = vfade_s7;
				default:  v_c = 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		res_s8.row_echo       <= ctl_s7.row;
		res_s8.brightness     <= v_c;
		res_s8.lit            <= (v_c != 8'd0);
		res_s8.hue_out        <= (v_c != 8'd0) ? cfg.hue : 8'd0;
		res_s8.saturation_out <= (v_c != 8'd0) ? cfg.sat : 8'd0;
	end

	assign done   = vld_s8;
	assign result = res_s8;

	`ASSERT_CLK(a_lit_matches, done |-> (result.lit == (result.brightness != 8'd0)), "lit disagrees with brightness")
	`ASSERT_CLK(a_dark_no_color, (done && !result.lit) |-> (result.hue_out == 8'd0 && result.saturation_out == 8'd0), "unlit row carries color")
	`ASSERT_CLK(a_flash_full_base, (vld_s7 && ctl_s7.phase == PH_FLASH) |-> (vfl_s7 >= cfg.base), "flash boost below base level")

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the charging pulse row brightness core.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cpr_pkg::*;

	localparam int unsigned FRAC = 16;
	localparam longint unsigned ONE = 64'd1 << FRAC;
	localparam int unsigned LATENCY = FRAC + 40;
	localparam int unsigned WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cpr_item_t item = '0;
	logic done;
	cpr_result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CPR_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	charging_pulse_row_brightness_core #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// shadow copy of the register file
	logic [15:0] step_ms, flash_len, fade_len;
	logic [7:0] base_lvl, hue_val, sat_val;
	logic [8:0] rows_val;

	cpr_item_t pending_rows[$];
	cpr_result_t expected_rows[$];
	int errors = 0;
	int idle_cycles = 0;
	int gap_left = 0;

	function automatic longint unsigned ease(longint unsigned p);
		longint unsigned c, f;
		if (p == 0) return 0;
		if (p >= ONE) return ONE;
		if (p < (ONE >> 1)) begin
			c = (((p * p) >> FRAC) * p) >> FRAC;
			return 4 * c;
		end
		f = 2 * ONE - 2 * p;
		c = (((f * f) >> FRAC) * f) >> FRAC;
		return ONE - (c >> 1);
	endfunction

	// piecewise-linear 8-bit sine
	function automatic logic [7:0] wave8(logic [7:0] theta);
		logic [7:0] segtab[8];
		logic [7:0] off, sec, b, m, y;
		int seg;
		segtab = '{8'd0, 8'd49, 8'd49, 8'd41, 8'd90, 8'd27, 8'd117, 8'd10};
		off = theta[6] ? 8'(255 - theta) : theta;
		off = off & 8'h3F;
		sec = off & 8'h0F;
		if (theta[6]) sec = sec + 1;
		seg = off >> 4;
		b = segtab[(seg * 2) & 7];
		m = segtab[(seg * 2 + 1) & 7];
		y = 8'((int'(m) * int'(sec)) >> 4) + b;
		if (theta[7]) y = 8'd0 - y;
		return y + 8'd128;
	endfunction

	function automatic cpr_result_t row_level(cpr_item_t it);
		cpr_result_t r;
		longint unsigned h, asc, cyc, t, v, g, s, d, e, tf, add, base;
		logic [7:0] f;
		h = rows_val;
		if (h < 1) h = 1;
		if (h > CPR_MAX_ROWS) h = CPR_MAX_ROWS;
		base = base_lvl;
		asc = h * step_ms;
		cyc = asc + flash_len + fade_len;
		if (cyc == 0) cyc = 1;
		t = longint'(it.now_ms) % cyc;
		v = 0;
		if (it.row_index < h) begin
			if (t < asc) begin
				g = ease(t * ONE / asc);
				s = (h - 1 - it.row_index) * step_ms;
				if (t >= s) begin
					d = t - s;
					if (d < step_ms) begin
						e = ease(d * ONE / step_ms);
						v = (base * e * g) >> (2 * FRAC);
					end else begin
						v = (base * g) >> FRAC;
					end
				end
			end else if (t < asc + flash_len) begin
				v = base;
				if (it.row_index == 0) begin
					tf = t - asc;
					f = 8'(tf * 255 / flash_len);
					add = (255 - base) * wave8(f) / 255;
					v = base + add;
				end
			end else if (fade_len != 0) begin
				tf = t - asc - flash_len;
				e = ease(tf * ONE / fade_len);
				v = (base * (ONE - e)) >> FRAC;
			end
		end
		if (v > 255) v = 255;
		r.row_echo = it.row_index;
		r.brightness = 8'(v);
		r.lit = v > 0;
		r.hue_out = r.lit ? hue_val : 8'd0;
		r.saturation_out = r.lit ? sat_val : 8'd0;
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// driver: one beat per accepted cycle, random gaps between
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_rows.push_back(row_level(item));
			end
			if (start && busy) begin
				// hold current beat
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_rows.size() > 0) begin
				item <= pending_rows.pop_front();
				start <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cpr_result_t exp_r;
		if (arst_n) begin
			if (done) begin
				if (expected_rows.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					errors <= errors + 1;
				end else begin
					exp_r = expected_rows.pop_front();
					if (exp_r !== result) begin
						$display("%0t: mismatch expected %h actual %h", $time, exp_r, result);
						errors <= errors + 1;
					end
				end
			end
			// any accepted beat or register write counts as progress
			if ((start && !busy) || done || (psel && penable && pwrite))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic reg_write(cpr_reg_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= CPR_ADDR_W'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_STEP: step_ms = val[15:0];
			REG_FLASH: flash_len = val[15:0];
			REG_FADE: fade_len = val[15:0];
			REG_BASE: base_lvl = val[7:0];
			REG_ROWS: rows_val = val[8:0];
			REG_HUE: hue_val = val[7:0];
			default: sat_val = val[7:0];
		endcase
	endtask

	// let everything in flight drain
	task automatic drain();
		while (pending_rows.size() > 0 || start) @(posedge clk);
		while (expected_rows.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_now(longint unsigned cyc);
		if ($urandom_range(0, 3) == 0) return $urandom();
		return 32'($urandom_range(0, 32'(cyc * 3)));
	endfunction

	task automatic random_rows(int n);
		cpr_item_t it;
		longint unsigned h, cyc;
		h = (rows_val == 0) ? 1 : (rows_val > 256 ? 256 : rows_val);
		cyc = h * step_ms + flash_len + fade_len + 1;
		for (int i = 0; i < n; i++) begin
			it.now_ms = rand_now(cyc);
			it.row_index = ($urandom_range(0, 7) == 0) ? 8'($urandom()) :
				8'($urandom_range(0, 32'(h - 1)));
			pending_rows.push_back(it);
		end
	endtask

	task automatic set_all(int s, int fl, int fa, int b, int r, int hu, int sa);
		reg_write(REG_STEP, s);
		reg_write(REG_FLASH, fl);
		reg_write(REG_FADE, fa);
		reg_write(REG_BASE, b);
		reg_write(REG_ROWS, r);
		reg_write(REG_HUE, hu);
		reg_write(REG_SAT, sa);
	endtask

	initial begin
		cpr_item_t it;
		step_ms = 40; flash_len = 200; fade_len = 400; base_lvl = 128;
		rows_val = 8; hue_val = 96; sat_val = 255;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset values, phase edges, extremes of fields
		for (int k = 0; k < 24; k++) begin
			case (k)
				0: it = '{32'd0, 8'd7};
				1: it = '{32'd0, 8'd0};
				2: it = '{32'd39, 8'd7};
				3: it = '{32'd150, 8'd3};
				4: it = '{32'd319, 8'd0};
				5: it = '{32'd320, 8'd0};
				6: it = '{32'd420, 8'd0};
				7: it = '{32'd420, 8'd5};
				8: it = '{32'd519, 8'd0};
				9: it = '{32'd520, 8'd2};
				10: it = '{32'd700, 8'd2};
				11: it = '{32'd919, 8'd1};
				12: it = '{32'hFFFFFFFF, 8'd0};
				13: it = '{32'hFFFFFFFF, 8'hFF};
				14: it = '{32'd100, 8'd8};
				15: it = '{32'hAAAAAAAA, 8'h55};
				16: it = '{32'h55555555, 8'hAA};
				default: it = '{32'($urandom_range(0, 919)), 8'($urandom_range(0, 7))};
			endcase
			pending_rows.push_back(it);
		end
		drain();

		// extremes: zero step, full rows, bright base
		set_all(0, 1, 1, 255, 256, 0, 0);
		random_rows(60);
		drain();
		// zero cycle length and zero row count
		set_all(0, 0, 0, 200, 0, 255, 255);
		random_rows(20);
		drain();
		// zero flash, large step, many rows
		set_all(65535, 0, 65535, 0, 511, 17, 200);
		random_rows(30);
		drain();
		// long flash, rows of 1
		set_all(3, 65535, 7, 90, 1, 200, 17);
		random_rows(60);
		drain();
		// mixed random settings
		for (int p = 0; p < 8; p++) begin
			set_all($urandom_range(0, 60), $urandom_range(0, 300), $urandom_range(0, 500),
				$urandom_range(0, 255), $urandom_range(1, 40), $urandom(), $urandom());
			random_rows(55);
			drain();
		end
		if (errors == 0 && expected_rows.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_divlane.sv
hw/rtl/cpr_ease.sv
hw/rtl/cpr_cfg.sv
hw/rtl/charging_pulse_row_brightness_core.sv
bench/tb_top.sv
